// ----- design/rycc420_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rycc420_pkg
// Shared constants for the RGB to YCbCr 4:2:0 macroblock packer: luma and
// chroma coefficients (16 fractional bits) and the chroma bias.
// ----------------------------------------------------------------------------
package rycc420_pkg;

  localparam int FRAC_BITS = 16;

  // Luma weights, unsigned
  localparam logic [16:0] COEF_YR = 17'd19595;
  localparam logic [16:0] COEF_YG = 17'd38470;
  localparam logic [16:0] COEF_YB = 17'd7471;

  // Chroma scale factors, applied to signed differences
  localparam logic signed [17:0] COEF_CB = 18'sd36962;
  localparam logic signed [17:0] COEF_CR = 18'sd46727;

  localparam logic [7:0] CHROMA_BIAS = 8'd128;

  localparam logic [7:0] LAST_INDEX = 8'hFF;

  // Control carried along the pipeline with each beat
  typedef struct packed {
    logic       valid;
    logic [7:0] pixel_index;
  } stage_ctl_t;

endpackage

// ----- design/rgb_to_ycbcr420_macroblock_packer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_macroblock_packer_core
// Four register stages (luma products, luma sum and chroma differences,
// chroma products, output register) carry each input beat to the output.
// Throughput: one pixel per cycle when not stalled.
// Each stage holds its beat under stall and bubbles close up.
// Reset (rst, synchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr420_macroblock_packer_core
  import rycc420_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] pixel_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] luma,
  output logic [7:0] luma_offset,
  output logic       chroma_valid,
  output logic [7:0] chroma_blue,
  output logic [7:0] chroma_red,
  output logic [5:0] chroma_offset,
  output logic       macroblock_done
);

  // stage 1: luma partial products
  stage_ctl_t  s1;
  logic [23:0] prod_r;
  logic [23:0] prod_g;
  logic [23:0] prod_b;
  logic [7:0]  s1_red;
  logic [7:0]  s1_blue;

  // stage 2: luma and chroma differences
  stage_ctl_t        s2;
  logic [7:0]        s2_luma;
  logic signed [8:0] diff_b;
  logic signed [8:0] diff_r;

  // stage 3: chroma products
  stage_ctl_t         s3;
  logic [7:0]         s3_luma;
  logic signed [25:0] prod_cb;
  logic signed [25:0] prod_cr;

  logic ready_s1;
  logic ready_s2;
  logic ready_s3;
  logic ready_out;

  logic [23:0]       luma_sum;
  logic [7:0]        luma_next;
  logic [3:0]        row;
  logic [3:0]        col;
  logic              even_pos;

  // a stage may load when it is empty or its beat moves on
  assign ready_out = !out_valid || !out_stall;
  assign ready_s3  = !s3.valid || ready_out;
  assign ready_s2  = !s2.valid || ready_s3;
  assign ready_s1  = !s1.valid || ready_s2;
  assign in_stall  = !ready_s1;

  assign luma_sum  = prod_r + prod_g + prod_b;
  assign luma_next = luma_sum[FRAC_BITS +: 8];

  assign row      = s3.pixel_index[7:4];
  assign col      = s3.pixel_index[3:0];
  assign even_pos = !row[0] && !col[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      s3.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_s1) begin
        s1.valid <= in_valid;
      end
      if (ready_s2) begin
        s2.valid <= s1.valid;
      end
      if (ready_s3) begin
        s3.valid <= s2.valid;
      end
      if (ready_out) begin
        out_valid <= s3.valid;
      end
    end

    if (ready_s1 && in_valid) begin
      s1.pixel_index <= pixel_index;
      prod_r         <= 24'(COEF_YR) * 24'(red);
      prod_g         <= 24'(COEF_YG) * 24'(green);
      prod_b         <= 24'(COEF_YB) * 24'(blue);
      s1_red         <= red;
      s1_blue        <= blue;
    end
    if (ready_s2 && s1.valid) begin
      s2.pixel_index <= s1.pixel_index;
      s2_luma        <= luma_next;
      diff_b         <= $signed({1'b0, s1_blue}) - $signed({1'b0, luma_next});
      diff_r         <= $signed({1'b0, s1_red}) - $signed({1'b0, luma_next});
    end
    if (ready_s3 && s2.valid) begin
      s3.pixel_index <= s2.pixel_index;
      s3_luma        <= s2_luma;
      prod_cb        <= 26'(COEF_CB) * 26'(diff_b);
      prod_cr        <= 26'(COEF_CR) * 26'(diff_r);
    end
    if (ready_out && s3.valid) begin
      luma            <= s3_luma;
      luma_offset     <= {row[3], col[3], row[2:0], col[2:0]};
      chroma_valid    <= even_pos;
      macroblock_done <= (s3.pixel_index == LAST_INDEX);
      // floor shift keeps the low 8 bits of the product's integer part
      if (even_pos) begin
        chroma_blue   <= prod_cb[FRAC_BITS +: 8] + CHROMA_BIAS;
        chroma_red    <= prod_cr[FRAC_BITS +: 8] + CHROMA_BIAS;
        chroma_offset <= {row[3:1], col[3:1]};
      end else begin
        chroma_blue   <= 8'd0;
        chroma_red    <= 8'd0;
        chroma_offset <= 6'd0;
      end
    end
  end

  // chroma fields are zero on odd positions
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !chroma_valid |->
      chroma_blue == 8'd0 && chroma_red == 8'd0 && chroma_offset == 6'd0)
    else $error("chroma fields not cleared on odd position");

  // the last pixel maps to the last luma byte and carries no chroma
  assert property (@(posedge clk) disable iff (rst)
    out_valid && macroblock_done |-> luma_offset == 8'hFF && !chroma_valid)
    else $error("last pixel offset mismatch");

  // a beat in stage 3 held by a stalled output stays put
  assert property (@(posedge clk) disable iff (rst)
    s3.valid && out_valid && out_stall |=> s3.valid && $stable(prod_cb))
    else $error("stage 3 beat lost under stall");

  // a beat leaving stage 1 always lands in stage 2
  assert property (@(posedge clk) disable iff (rst)
    s1.valid && ready_s2 |=> s2.valid)
    else $error("stage 1 beat dropped");

endmodule
